// ===== hw/rtl/assert_macros.svh =====
// Shared assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/pia_pkg.sv =====
package pia_pkg;

  localparam int unsigned POS_W     = 7;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned CNT_OUT_W = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    status_e                status;
    logic                   found;
    logic [CNT_OUT_W-1:0]   entry_count;
  } result_t;

endpackage

// ===== hw/rtl/pia_ram.sv =====
module pia_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/pia_seq.sv =====
`include "assert_macros.svh"

module pia_seq #(
  parameter int unsigned Capacity = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  pia_pkg::op_e                    op_i,
  input  logic [pia_pkg::POS_W-1:0]       pos_i,
  input  logic [pia_pkg::VAL_W-1:0]       val_i,
  output logic                            ready_o,
  input  logic                            out_free_i,
  output logic                            done_o,
  output pia_pkg::result_t                result_o,
  output logic                            ram_we_o,
  output logic [$clog2(Capacity)-1:0]     ram_waddr_o,
  output logic [pia_pkg::VAL_W-1:0]       ram_wdata_o,
  output logic                            ram_re_o,
  output logic [$clog2(Capacity)-1:0]     ram_raddr_o,
  input  logic [pia_pkg::VAL_W-1:0]       ram_rdata_i
);
  import pia_pkg::*;

  localparam int unsigned AW    = $clog2(Capacity);
  localparam int unsigned CW    = $clog2(Capacity + 1);
  localparam int unsigned CMP_W = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  status_e           status_q, status_d;
  logic              found_q, found_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     pos_q, pos_d;
  logic [VAL_W-1:0]  val_q, val_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     pend_addr_q, pend_addr_d;

  logic [CW-1:0]     idx_m1;
  logic [CW-1:0]     idx_p1;
  logic [CMP_W-1:0]  pos_x;
  logic [CMP_W-1:0]  count_x;

  assign idx_m1  = idx_q - CW'(1);
  assign idx_p1  = idx_q + CW'(1);
  assign pos_x   = CMP_W'(pos_i);
  assign count_x = CMP_W'(count_q);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    status_d    = status_q;
    found_d     = found_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    val_d       = val_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = pend_addr_q;
    ram_wdata_o = ram_rdata_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = idx_q[AW-1:0];
    done_o      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d     = op_i;
          val_d    = val_i;
          pos_d    = CW'(pos_i);
          status_d = ST_OK;
          found_d  = 1'b0;
          state_d  = S_RUN;
          unique case (op_i)
            OP_INSERT: begin
              idx_d = count_q;
              if (count_q == CW'(Capacity)) begin
                status_d = ST_FULL;
                state_d  = S_DONE;
              end else if (pos_x > count_x) begin
                status_d = ST_BAD_POS;
                state_d  = S_DONE;
              end
            end
            OP_REMOVE: begin
              idx_d = CW'(pos_i) + CW'(1);
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_DONE;
              end else if (pos_x >= count_x) begin
                status_d = ST_BAD_POS;
                state_d  = S_DONE;
              end
            end
            OP_SEARCH: begin
              idx_d = '0;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_RUN: begin
        unique case (op_q)
          OP_INSERT: begin
            // entries move up one place, top first
            ram_we_o = pend_q;
            if (idx_q > pos_q) begin
              ram_re_o    = 1'b1;
              ram_raddr_o = idx_m1[AW-1:0];
              pend_d      = 1'b1;
              pend_addr_d = idx_q[AW-1:0];
              idx_d       = idx_m1;
            end else if (!pend_q) begin
              ram_we_o    = 1'b1;
              ram_waddr_o = pos_q[AW-1:0];
              ram_wdata_o = val_q;
              count_d     = count_q + CW'(1);
              state_d     = S_DONE;
            end
          end
          OP_REMOVE: begin
            ram_we_o = pend_q;
            if (idx_q < count_q) begin
              ram_re_o    = 1'b1;
              pend_d      = 1'b1;
              pend_addr_d = idx_m1[AW-1:0];
              idx_d       = idx_p1;
            end else if (!pend_q) begin
              count_d = count_q - CW'(1);
              state_d = S_DONE;
            end
          end
          OP_SEARCH: begin
            if (pend_q && ram_rdata_i == val_q) begin
              found_d = 1'b1;
            end
            if (idx_q < count_q) begin
              ram_re_o = 1'b1;
              pend_d   = 1'b1;
              idx_d    = idx_p1;
            end else if (!pend_q) begin
              state_d = S_DONE;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_DONE: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_NONE;
      status_q    <= ST_OK;
      found_q     <= 1'b0;
      count_q     <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      val_q       <= '0;
      pend_q      <= 1'b0;
      pend_addr_q <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      status_q    <= status_d;
      found_q     <= found_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      val_q       <= val_d;
      pend_q      <= pend_d;
      pend_addr_q <= pend_addr_d;
    end
  end

  assign ready_o              = (state_q == S_IDLE);
  assign result_o.status      = status_q;
  assign result_o.found       = found_q;
  assign result_o.entry_count = CNT_OUT_W'(count_q);

  `ASSERT_RST(a_count_bound, clk_i, rst_ni, count_q <= CW'(Capacity),
              "count above capacity")
  `ASSERT_RST(a_no_rw_clash, clk_i, rst_ni,
              !(ram_we_o && ram_re_o && ram_waddr_o == ram_raddr_o),
              "read and write hit the same entry")
  `ASSERT_RST(a_count_only_at_end, clk_i, rst_ni,
              (state_q == S_IDLE) |=> $stable(count_q),
              "count moved outside an operation")
  `ASSERT_RST(a_pend_only_running, clk_i, rst_ni, pend_q |-> (state_q == S_RUN),
              "read in flight outside the shift loop")

endmodule

// ===== hw/rtl/positional_array_insert_remove_search.sv =====
// Positional array: an ordered list of signed 32-bit values with insert,
// remove and search, held in one single-port-write, registered-read RAM.
// Input transfer on s_axis: op (0 insert, 1 remove, 2 search, 3 no-op),
// position and value. Each input transfer gives exactly one output transfer
// on m_axis: status, found flag and the entry count after the operation.
// Work goes one entry per cycle through the RAM read port: insert moves
// the entries from the top down to the position up one place and then
// writes the value, remove moves the entries above the position down one
// place, and search reads every entry and compares it with the value;
// rejected and no-op items move or read no entry.
// One item is in progress at a time; s_axis_tready drops from the
// transfer until the result has moved into the output register, which may
// hold a previous result while the next item runs. If m_axis stalls, the
// finished item waits in the sequencer and no new item is taken.
// Reset clears the entry count and the output valid; RAM contents are left
// as they are and are never read beyond the count, so no clearing pass.
`include "assert_macros.svh"

module positional_array_insert_remove_search #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // op[1:0], position[8:2], value[40:9], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // status[1:0], found[2], entry_count[9:3], zero pad
);
  import pia_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);

  logic              seq_ready;
  logic              seq_done;
  logic              out_free;
  result_t           seq_res;
  result_t           out_q;
  logic              out_valid_q;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [VAL_W-1:0]  ram_wdata, ram_rdata;

  assign s_axis_tready = seq_ready;
  assign out_free      = !out_valid_q || m_axis_tready;

  pia_seq #(
    .Capacity (CAPACITY)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (s_axis_tvalid && seq_ready),
    .op_i        (op_e'(s_axis_tdata[1:0])),
    .pos_i       (s_axis_tdata[8:2]),
    .val_i       (s_axis_tdata[40:9]),
    .ready_o     (seq_ready),
    .out_free_i  (out_free),
    .done_o      (seq_done),
    .result_o    (seq_res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  pia_ram #(
    .Width (VAL_W),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_done) begin
      out_q <= seq_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_q.entry_count, out_q.found, out_q.status};

  `ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_q,
                 "result valid during reset")
  `ASSERT_RST(a_done_needs_room, clk_i, rst_ni,
              seq_done |-> (!out_valid_q || m_axis_tready),
              "result written over an untaken one")
  `ASSERT_RST(a_no_take_while_busy, clk_i, rst_ni,
              (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready,
              "second item taken while one is in progress")

endmodule

// ===== sim/positional_array_insert_remove_search_tb.sv =====
module positional_array_insert_remove_search_tb;
  import pia_pkg::*;

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned RAND_ITEMS   = 1900;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam longint      RUN_LIMIT    = 30_000_000;

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED, MODE_NOISE} mix_e;

  class array_scoreboard;
    logic [VAL_W-1:0] shadow [CAPACITY];
    int unsigned      held;
    result_t          pending_outcomes [$];
    int unsigned      errors;
    int unsigned      n_checked;

    function new();
      held      = 0;
      errors    = 0;
      n_checked = 0;
    endfunction

    task report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // Update the shadow array for one accepted op and queue its outcome.
    function void apply_op(input op_e op, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] val);
      result_t r;
      r.status = ST_OK;
      r.found  = 1'b0;
      case (op)
        OP_INSERT: begin
          if (held >= CAPACITY) r.status = ST_FULL;
          else if (pos > held) r.status = ST_BAD_POS;
          else begin
            for (int i = held; i > pos; i--) shadow[i] = shadow[i-1];
            shadow[pos] = val;
            held++;
          end
        end
        OP_REMOVE: begin
          if (held == 0) r.status = ST_EMPTY;
          else if (pos >= held) r.status = ST_BAD_POS;
          else begin
            for (int i = pos; i + 1 < held; i++) shadow[i] = shadow[i+1];
            held--;
          end
        end
        OP_SEARCH: begin
          for (int i = 0; i < held; i++)
            if (shadow[i] == val) r.found = 1'b1;
        end
        default: ;
      endcase
      r.entry_count = held[CNT_OUT_W-1:0];
      pending_outcomes.push_back(r);
    endfunction

    task check_outcome(input logic [15:0] t);
      result_t want;
      status_e got_status;
      got_status = status_e'(t[1:0]);
      n_checked++;
      if (pending_outcomes.size() == 0) begin
        report_mismatch($sformatf("unexpected result tdata=%h", t));
      end else begin
        want = pending_outcomes.pop_front();
        if (got_status !== want.status)
          report_mismatch($sformatf("result %0d status %0d, want %0d",
                                    n_checked, got_status, want.status));
        if (t[2] !== want.found)
          report_mismatch($sformatf("result %0d found %0b, want %0b",
                                    n_checked, t[2], want.found));
        if (t[9:3] !== want.entry_count)
          report_mismatch($sformatf("result %0d count %0d, want %0d",
                                    n_checked, t[9:3], want.entry_count));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // op[1:0], position[8:2], value[40:9], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // status[1:0], found[2], entry_count[9:3], zero pad

  array_scoreboard sb;
  bit              no_idle;

  positional_array_insert_remove_search #(.CAPACITY(CAPACITY)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Small pool so that searches and duplicates hit often.
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      4: return 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_op(input op_e op, input logic [POS_W-1:0] pos,
                         input logic [VAL_W-1:0] val);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {7'b0, val, pos, op};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.apply_op(op, pos, val);
  endtask

  task automatic random_op(input mix_e mode);
    int unsigned       r;
    int unsigned       n;
    int unsigned       w_ins;
    int unsigned       w_rem;
    int unsigned       w_srch;
    op_e               op;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  val;
    n   = sb.held;
    r   = $urandom_range(0, 99);
    pos = POS_W'($urandom_range(0, 127));
    val = pick_value();
    case (mode)
      MODE_GROW:   begin w_ins = 70; w_rem = 10; w_srch = 15; end
      MODE_SHRINK: begin w_ins = 10; w_rem = 70; w_srch = 15; end
      MODE_MIXED:  begin w_ins = 35; w_rem = 30; w_srch = 30; end
      default:     begin w_ins = 0;  w_rem = 0;  w_srch = 0;  end
    endcase
    if (r < w_ins) begin
      op = OP_INSERT;
      case ($urandom_range(0, 3))
        0:       pos = '0;
        1:       pos = POS_W'(n);
        default: pos = POS_W'($urandom_range(0, n));
      endcase
    end else if (r < w_ins + w_rem) begin
      op = OP_REMOVE;
      val = $urandom;
      if (n != 0) begin
        case ($urandom_range(0, 3))
          0:       pos = '0;
          1:       pos = POS_W'(n - 1);
          default: pos = POS_W'($urandom_range(0, n - 1));
        endcase
      end
    end else if (r < w_ins + w_rem + w_srch) begin
      op = OP_SEARCH;
      if (n != 0 && $urandom_range(0, 9) < 6) val = sb.shadow[$urandom_range(0, n - 1)];
    end else begin
      // anything at all: bad positions, the unused op, raw values
      op  = op_e'($urandom_range(0, 3));
      val = $urandom;
    end
    send_op(op, pos, val);
  endtask

  // receiver: random stalls, one long hold-off once traffic is flowing
  initial begin
    int unsigned stall_left;
    bit          held_off;
    stall_left = 0;
    held_off   = 1'b0;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!held_off && sb.n_checked >= 300) begin
        held_off = 1'b1;
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
        stall_left = pick_gap();
      end
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_outcome(m_axis_tdata);
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned len;
    mix_e        mode;
    sb = new();
    no_idle       = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty cases first, then a small array built and torn down
    send_op(OP_REMOVE, 7'd0,   32'h0);
    send_op(OP_REMOVE, 7'd127, 32'hffff_ffff);   // empty wins over position
    send_op(OP_SEARCH, 7'd0,   32'h0);
    send_op(OP_NONE,   7'd127, 32'hffff_ffff);
    send_op(OP_INSERT, 7'd1,   32'h1);           // past the end
    send_op(OP_INSERT, 7'd0,   32'h7fff_ffff);
    send_op(OP_INSERT, 7'd1,   32'h8000_0000);   // append
    send_op(OP_INSERT, 7'd0,   32'h0);           // front
    send_op(OP_INSERT, 7'd3,   32'hffff_ffff);
    send_op(OP_INSERT, 7'd2,   32'h5);           // middle
    send_op(OP_SEARCH, 7'd127, 32'h8000_0000);
    send_op(OP_SEARCH, 7'd0,   32'h1234_5678);
    send_op(OP_SEARCH, 7'd0,   32'hffff_ffff);
    send_op(OP_REMOVE, 7'd5,   32'h0);           // one past the last
    send_op(OP_REMOVE, 7'd127, 32'h0);
    send_op(OP_INSERT, 7'd127, 32'h2);
    send_op(OP_NONE,   7'd0,   32'h0);
    send_op(OP_REMOVE, 7'd4,   32'h0);
    send_op(OP_REMOVE, 7'd1,   32'h0);
    send_op(OP_REMOVE, 7'd0,   32'h0);
    send_op(OP_REMOVE, 7'd0,   32'h0);           // front of two: only one goes
    send_op(OP_SEARCH, 7'd0,   32'h7fff_ffff);
    send_op(OP_REMOVE, 7'd0,   32'h0);
    send_op(OP_SEARCH, 7'd0,   32'h7fff_ffff);

    // random phases; the first one is a growing phase, mostly inserts
    sent = 0;
    mode = MODE_GROW;
    len  = 100;
    while (sent < RAND_ITEMS) begin
      for (int i = 0; i < len && sent < RAND_ITEMS; i++) begin
        random_op(mode);
        sent++;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: mode = MODE_GROW;
        3, 4, 5: mode = MODE_SHRINK;
        6, 7, 8: mode = MODE_MIXED;
        default: mode = MODE_NOISE;
      endcase
      len     = $urandom_range(20, 90);
      no_idle = ($urandom_range(0, 5) == 0);
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending_outcomes.size() != 0)
      sb.report_mismatch($sformatf("%0d results never came", sb.pending_outcomes.size()));
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
